/* rtl/hsc_pkg.sv */
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared widths, codes and types of the horizontal segment closeness block.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

   localparam int COORD_W    = 32;
   localparam int DIFF_W     = 33;
   localparam int EPS_W      = 31;
   localparam int TOL_W      = 16;
   localparam int NUM_W      = 36;
   localparam int KIND_W     = 2;
   localparam int CODE_W     = 3;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 31;

   localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POINT    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INTERVAL = 2'd2;

   localparam logic [CODE_W-1:0] CODE_NONE     = 3'd0;
   localparam logic [CODE_W-1:0] CODE_FULL     = 3'd1;
   localparam logic [CODE_W-1:0] CODE_PT_START = 3'd2;
   localparam logic [CODE_W-1:0] CODE_PT_END   = 3'd3;
   localparam logic [CODE_W-1:0] CODE_PT_ROOT  = 3'd4;
   localparam logic [CODE_W-1:0] CODE_IV_START = 3'd5;
   localparam logic [CODE_W-1:0] CODE_IV_END   = 3'd6;
   localparam logic [CODE_W-1:0] CODE_IV_MID   = 3'd7;

   localparam logic [CSR_ADDR_W-1:0] CSR_EPS = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOL = 1'd1;

   typedef struct packed {
      logic             zero;
      logic             one;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] den;
   } lane_type;

endpackage

`default_nettype wire

/* rtl/hsc_front.sv */
// ----------------------------------------------------------------------------
// hsc_front
// Three register stages: differences, case classification with root
// numerators, and root range selection with saturation flags.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         enable,
   input  wire logic                         in_valid,
   input  wire logic [hsc_pkg::COORD_W-1:0]  first_start_x,
   input  wire logic [hsc_pkg::COORD_W-1:0]  first_end_x,
   input  wire logic [hsc_pkg::COORD_W-1:0]  second_start_x,
   input  wire logic [hsc_pkg::COORD_W-1:0]  second_end_x,
   input  wire logic [hsc_pkg::EPS_W-1:0]    eps,
   input  wire logic [hsc_pkg::TOL_W-1:0]    tol,
   output logic                              out_valid,
   output logic [hsc_pkg::CODE_W-1:0]        out_code,
   output hsc_pkg::lane_type                 out_lane1,
   output hsc_pkg::lane_type                 out_lane2
);
   import hsc_pkg::*;

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0] d0_ff, d1_ff;
   logic signed [DIFF_W-1:0] d0_in, d1_in;

   logic signed [DIFF_W:0]   d0x, d1x, m0x, m1x;
   logic [DIFF_W-1:0]        m0, m1;
   logic                     eq0, eq1, near0, near1, same_sign, tol_mode;
   logic signed [NUM_W-1:0]  d0s, d1s, eps_s, den_t, n1_t, n2_t;
   logic signed [NUM_W-1:0]  den_in, n1_in, n2_in;
   logic [CODE_W-1:0]        code_in;
   logic signed [NUM_W-1:0]  den_ff, n1_ff, n2_ff;
   logic [CODE_W-1:0]        code2_ff, code3_ff;

   logic                     in1, in2;
   logic signed [NUM_W-1:0]  a1, a2;
   lane_type                 lane1_in, lane2_in, lane1_ff, lane2_ff;

   assign d0_in = $signed({first_start_x[COORD_W-1], first_start_x})
                - $signed({second_start_x[COORD_W-1], second_start_x});
   assign d1_in = $signed({first_end_x[COORD_W-1], first_end_x})
                - $signed({second_end_x[COORD_W-1], second_end_x});

   always_comb begin
      d0x = $signed({d0_ff[DIFF_W-1], d0_ff});
      d1x = $signed({d1_ff[DIFF_W-1], d1_ff});
      m0x = (d0x < 0) ? -d0x : d0x;
      m1x = (d1x < 0) ? -d1x : d1x;
      m0 = m0x[DIFF_W-1:0];
      m1 = m1x[DIFF_W-1:0];
      tol_mode = {16'd0, eps} > {16'd0, tol, 15'd0} >> 15;
      eq0 = m0 <= {17'd0, tol};
      eq1 = m1 <= {17'd0, tol};
      near0 = m0 <= {2'd0, eps};
      near1 = m1 <= {2'd0, eps};
      same_sign = (d0_ff > 0 && d1_ff > 0) || (d0_ff < 0 && d1_ff < 0);
      d0s = $signed({{(NUM_W-DIFF_W){d0_ff[DIFF_W-1]}}, d0_ff});
      d1s = $signed({{(NUM_W-DIFF_W){d1_ff[DIFF_W-1]}}, d1_ff});
      eps_s = $signed({{(NUM_W-EPS_W){1'b0}}, eps});
      den_t = d1s - d0s;
      n1_t = eps_s - d0s;
      n2_t = -eps_s - d0s;
      if (tol_mode) begin
         if (den_t < 0) begin
            den_in = -den_t;
            n1_in = -n1_t;
            n2_in = -n2_t;
         end else begin
            den_in = den_t;
            n1_in = n1_t;
            n2_in = n2_t;
         end
         priority if (near0 && near1) code_in = CODE_FULL;
         else if (same_sign && !near0 && !near1) code_in = CODE_NONE;
         else if (near0) code_in = CODE_IV_START;
         else if (near1) code_in = CODE_IV_END;
         else code_in = CODE_IV_MID;
      end else begin
         n1_in = $signed({{(NUM_W-DIFF_W){1'b0}}, m0});
         n2_in = n1_in;
         den_in = n1_in + $signed({{(NUM_W-DIFF_W){1'b0}}, m1});
         priority if (eq0 && eq1) code_in = CODE_FULL;
         else if (eq0) code_in = CODE_PT_START;
         else if (eq1) code_in = CODE_PT_END;
         else if (same_sign) code_in = CODE_NONE;
         else code_in = CODE_PT_ROOT;
      end
   end

   always_comb begin
      in1 = n1_ff >= 0 && n1_ff <= den_ff;
      in2 = n2_ff >= 0 && n2_ff <= den_ff;
      a1 = n1_ff;
      a2 = n2_ff;
      if (!in1) a1 = n2_ff;
      else if (!in2) a2 = n1_ff;
      lane1_in.zero = den_ff <= 0 || a1 <= 0;
      lane1_in.one = a1 >= den_ff;
      lane1_in.num = a1;
      lane1_in.den = den_ff;
      lane2_in.zero = den_ff <= 0 || a2 <= 0;
      lane2_in.one = a2 >= den_ff;
      lane2_in.num = a2;
      lane2_in.den = den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d0_ff <= d0_in;
         d1_ff <= d1_in;
         den_ff <= den_in;
         n1_ff <= n1_in;
         n2_ff <= n2_in;
         code2_ff <= code_in;
         code3_ff <= code2_ff;
         lane1_ff <= lane1_in;
         lane2_ff <= lane2_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_code = code3_ff;
   assign out_lane1 = lane1_ff;
   assign out_lane2 = lane2_ff;

endmodule

`default_nettype wire

/* rtl/hsc_div.sv */
// ----------------------------------------------------------------------------
// hsc_div
// Pipelined restoring divider: one quotient bit of num/den per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_div #(
   parameter int PORTION_FRAC_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire hsc_pkg::lane_type        lane,
   output logic [PORTION_FRAC_BITS:0]    raw,
   output logic                          zero,
   output logic                          one
);
   import hsc_pkg::*;

   localparam int STEPS = PORTION_FRAC_BITS + 1;

   logic [NUM_W-1:0]             rem_ff [STEPS];
   logic [NUM_W-1:0]             den_ff [STEPS];
   logic [PORTION_FRAC_BITS:0]   quo_ff [STEPS];
   logic                         zero_ff [STEPS];
   logic                         one_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [NUM_W-1:0]           rem_prev, den_prev, rem_sh;
      logic [PORTION_FRAC_BITS:0] quo_prev;
      logic                       zero_prev, one_prev, take;
      if (i == 0) begin : g_first
         assign rem_prev = lane.num;
         assign den_prev = lane.den;
         assign quo_prev = '0;
         assign zero_prev = lane.zero;
         assign one_prev = lane.one;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign zero_prev = zero_ff[i-1];
         assign one_prev = one_ff[i-1];
      end
      assign rem_sh = {rem_prev[NUM_W-2:0], 1'b0};
      assign take = rem_sh >= den_prev;
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i] <= take ? rem_sh - den_prev : rem_sh;
            den_ff[i] <= den_prev;
            quo_ff[i] <= {quo_prev[PORTION_FRAC_BITS-1:0], take};
            zero_ff[i] <= zero_prev;
            one_ff[i] <= one_prev;
         end
      end
   end

   assign raw = quo_ff[STEPS-1];
   assign zero = zero_ff[STEPS-1];
   assign one = one_ff[STEPS-1];

endmodule

`default_nettype wire

/* rtl/hsc_back.sv */
// ----------------------------------------------------------------------------
// hsc_back
// Rounds both roots, orders them and forms the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_back #(
   parameter int PORTION_FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          in_valid,
   input  wire logic [hsc_pkg::CODE_W-1:0]    code,
   input  wire logic [PORTION_FRAC_BITS:0]    raw1,
   input  wire logic                          zero1,
   input  wire logic                          one1,
   input  wire logic [PORTION_FRAC_BITS:0]    raw2,
   input  wire logic                          zero2,
   input  wire logic                          one2,
   output logic                               out_valid,
   output logic [hsc_pkg::KIND_W-1:0]         close_kind,
   output logic [PORTION_FRAC_BITS:0]         first_from,
   output logic [PORTION_FRAC_BITS:0]         first_to,
   output logic [PORTION_FRAC_BITS:0]         second_from,
   output logic [PORTION_FRAC_BITS:0]         second_to
);
   import hsc_pkg::*;

   localparam int PW = PORTION_FRAC_BITS + 1;
   localparam logic [PW-1:0] ONE = {1'b1, {PORTION_FRAC_BITS{1'b0}}};

   logic [PW:0]       t1, t2;
   logic [PW-1:0]     y1, y2, lo, hi, from_in, to_in;
   logic [KIND_W-1:0] kind_in;
   logic              valid_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [PW-1:0]     from_ff, to_ff;

   always_comb begin
      t1 = {1'b0, raw1} + (PW+1)'(1);
      t2 = {1'b0, raw2} + (PW+1)'(1);
      y1 = zero1 ? '0 : (one1 ? ONE : t1[PW:1]);
      y2 = zero2 ? '0 : (one2 ? ONE : t2[PW:1]);
      hi = (y1 > y2) ? y1 : y2;
      lo = (y1 > y2) ? y2 : y1;
      unique case (code)
         CODE_NONE: begin
            kind_in = KIND_NONE;
            from_in = '0;
            to_in = '0;
         end
         CODE_FULL: begin
            kind_in = KIND_INTERVAL;
            from_in = '0;
            to_in = ONE;
         end
         CODE_PT_START: begin
            kind_in = KIND_POINT;
            from_in = '0;
            to_in = '0;
         end
         CODE_PT_END: begin
            kind_in = KIND_POINT;
            from_in = ONE;
            to_in = ONE;
         end
         CODE_PT_ROOT: begin
            kind_in = KIND_POINT;
            from_in = y1;
            to_in = y1;
         end
         CODE_IV_START: begin
            kind_in = KIND_INTERVAL;
            from_in = '0;
            to_in = hi;
         end
         CODE_IV_END: begin
            kind_in = KIND_INTERVAL;
            from_in = lo;
            to_in = ONE;
         end
         default: begin
            kind_in = KIND_INTERVAL;
            from_in = lo;
            to_in = hi;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         kind_ff <= kind_in;
         from_ff <= from_in;
         to_ff <= to_in;
      end
   end

   assign out_valid = valid_ff;
   assign close_kind = kind_ff;
   assign first_from = from_ff;
   assign first_to = to_ff;
   assign second_from = from_ff;
   assign second_to = to_ff;

endmodule

`default_nettype wire

/* rtl/horizontal_segment_closeness.sv */
// ----------------------------------------------------------------------------
// horizontal_segment_closeness
// Finds where two segments over a shared vertical parameter lie within a
// horizontal tolerance of each other, as portions along both segments.
// ----------------------------------------------------------------------------
// The block takes one transfer per cycle unless req_stall is raised. Three
// front stages classify the pair and set up the roots, then a restoring
// divider spends one stage on each of the PORTION_FRAC_BITS + 1 quotient
// bits, and the last stage rounds and orders the roots into the output
// register. While a result is held by rsp_stall the whole pipeline holds
// and req_stall is raised.
`default_nettype none

module horizontal_segment_closeness #(
   parameter int PORTION_FRAC_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write,
   input  wire logic [hsc_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  wire logic [hsc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [hsc_pkg::COORD_W-1:0]      req_first_start_x,
   input  wire logic [hsc_pkg::COORD_W-1:0]      req_first_end_x,
   input  wire logic [hsc_pkg::COORD_W-1:0]      req_second_start_x,
   input  wire logic [hsc_pkg::COORD_W-1:0]      req_second_end_x,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [hsc_pkg::KIND_W-1:0]            rsp_close_kind,
   output logic [PORTION_FRAC_BITS:0]            rsp_first_from,
   output logic [PORTION_FRAC_BITS:0]            rsp_first_to,
   output logic [PORTION_FRAC_BITS:0]            rsp_second_from,
   output logic [PORTION_FRAC_BITS:0]            rsp_second_to
);
   import hsc_pkg::*;

   localparam int STEPS = PORTION_FRAC_BITS + 1;

   logic               enable;
   logic [EPS_W-1:0]   eps_ff;
   logic [TOL_W-1:0]   tol_ff;
   logic               f_valid;
   logic [CODE_W-1:0]  f_code;
   lane_type           f_lane1, f_lane2;
   logic [PORTION_FRAC_BITS:0] raw1, raw2;
   logic               zero1, one1, zero2, one2;
   logic               v_ff [STEPS];
   logic [CODE_W-1:0]  code_ff [STEPS];

   assign enable = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= '0;
         tol_ff <= TOL_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_EPS: eps_ff <= csr_wdata[EPS_W-1:0];
            default: tol_ff <= csr_wdata[TOL_W-1:0];
         endcase
      end
   end

   hsc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .in_valid       (req_valid),
      .first_start_x  (req_first_start_x),
      .first_end_x    (req_first_end_x),
      .second_start_x (req_second_start_x),
      .second_end_x   (req_second_end_x),
      .eps            (eps_ff),
      .tol            (tol_ff),
      .out_valid      (f_valid),
      .out_code       (f_code),
      .out_lane1      (f_lane1),
      .out_lane2      (f_lane2)
   );

   hsc_div #(.PORTION_FRAC_BITS(PORTION_FRAC_BITS)) u_div1 (
      .clock  (clock),
      .enable (enable),
      .lane   (f_lane1),
      .raw    (raw1),
      .zero   (zero1),
      .one    (one1)
   );

   hsc_div #(.PORTION_FRAC_BITS(PORTION_FRAC_BITS)) u_div2 (
      .clock  (clock),
      .enable (enable),
      .lane   (f_lane2),
      .raw    (raw2),
      .zero   (zero2),
      .one    (one2)
   );

   for (genvar i = 0; i < STEPS; i++) begin : g_tag
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (enable) begin
            v_ff[i] <= (i == 0) ? f_valid : v_ff[(i == 0) ? 0 : i-1];
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            code_ff[i] <= (i == 0) ? f_code : code_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   hsc_back #(.PORTION_FRAC_BITS(PORTION_FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (v_ff[STEPS-1]),
      .code        (code_ff[STEPS-1]),
      .raw1        (raw1),
      .zero1       (zero1),
      .one1        (one1),
      .raw2        (raw2),
      .zero2       (zero2),
      .one2        (one2),
      .out_valid   (rsp_valid),
      .close_kind  (rsp_close_kind),
      .first_from  (rsp_first_from),
      .first_to    (rsp_first_to),
      .second_from (rsp_second_from),
      .second_to   (rsp_second_to)
   );

endmodule

`default_nettype wire

/* verif/horizontal_segment_closeness_tb.sv */
// ----------------------------------------------------------------------------
// horizontal_segment_closeness_tb
// Drives segment pairs into the closeness block under several tolerance
// settings and idle patterns, predicts each closeness result in a local
// fixed-point model and checks every returned transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module horizontal_segment_closeness_tb;

   import hsc_pkg::*;

   localparam int PFB       = 16;
   localparam int LATENCY   = PFB + 5;
   localparam int MAX_CYCLE = 400000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [PFB:0]      f0;
      logic [PFB:0]      f1;
      logic [PFB:0]      s0;
      logic [PFB:0]      s1;
   } closeness_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [COORD_W-1:0] req_fs = '0, req_fe = '0, req_ss = '0, req_se = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [KIND_W-1:0] rsp_close_kind;
   logic [PFB:0] rsp_first_from, rsp_first_to, rsp_second_from, rsp_second_to;

   closeness_type expected_q[$];
   longint eps_val = 0;
   longint tol_val = 1;
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   horizontal_segment_closeness #(.PORTION_FRAC_BITS(PFB)) u_top (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_first_start_x(req_fs), .req_first_end_x(req_fe),
      .req_second_start_x(req_ss), .req_second_end_x(req_se),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_close_kind(rsp_close_kind),
      .rsp_first_from(rsp_first_from), .rsp_first_to(rsp_first_to),
      .rsp_second_from(rsp_second_from), .rsp_second_to(rsp_second_to)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [PFB:0] portion(longint num, longint den);
      longint q;
      if (den <= 0 || num <= 0) return '0;
      if (num >= den) return (PFB+1)'(1) << PFB;
      q = ((num <<< (PFB + 1)) + den) / (2 * den);
      return q[PFB:0];
   endfunction

   function automatic closeness_type predict_closeness(logic [COORD_W-1:0] fs, fe, ss, se);
      longint d0, d1, den, n1, n2;
      logic [PFB:0] one, y, y1, y2, lo, hi;
      logic same, near0, near1;
      closeness_type r;
      d0 = longint'($signed(fs)) - longint'($signed(ss));
      d1 = longint'($signed(fe)) - longint'($signed(se));
      one = (PFB+1)'(1) << PFB;
      same = (d0 > 0 && d1 > 0) || (d0 < 0 && d1 < 0);
      r = '{KIND_NONE, '0, '0, '0, '0};
      if (eps_val <= tol_val) begin
         near0 = magnitude(d0) <= tol_val;
         near1 = magnitude(d1) <= tol_val;
         if (near0 && near1) r = '{KIND_INTERVAL, '0, one, '0, one};
         else if (near0) r = '{KIND_POINT, '0, '0, '0, '0};
         else if (near1) r = '{KIND_POINT, one, one, one, one};
         else if (!same) begin
            y = portion(magnitude(d0), magnitude(d0) + magnitude(d1));
            r = '{KIND_POINT, y, y, y, y};
         end
      end else begin
         near0 = magnitude(d0) <= eps_val;
         near1 = magnitude(d1) <= eps_val;
         if (near0 && near1) r = '{KIND_INTERVAL, '0, one, '0, one};
         else if (!(same && !near0 && !near1)) begin
            den = d1 - d0;
            n1 = eps_val - d0;
            n2 = -eps_val - d0;
            if (den < 0) begin
               den = -den; n1 = -n1; n2 = -n2;
            end
            if (!(n1 >= 0 && n1 <= den)) n1 = n2;
            else if (!(n2 >= 0 && n2 <= den)) n2 = n1;
            y1 = portion(n1, den);
            y2 = portion(n2, den);
            hi = y1 > y2 ? y1 : y2;
            lo = y1 > y2 ? y2 : y1;
            if (near0) r = '{KIND_INTERVAL, '0, hi, '0, hi};
            else if (near1) r = '{KIND_INTERVAL, lo, one, lo, one};
            else r = '{KIND_INTERVAL, lo, hi, lo, hi};
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLE) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      closeness_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_close_kind, rsp_first_from, rsp_first_to,
                 rsp_second_from, rsp_second_to};
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
               $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            if (got.f0 !== want.f0)
               $display("%0t: first_from expected %0d actual %0d", $time, want.f0, got.f0);
            if (got.f1 !== want.f1)
               $display("%0t: first_to expected %0d actual %0d", $time, want.f1, got.f1);
            if (got.s0 !== want.s0)
               $display("%0t: second_from expected %0d actual %0d", $time, want.s0, got.s0);
            if (got.s1 !== want.s1)
               $display("%0t: second_to expected %0d actual %0d", $time, want.s1, got.s1);
            if (got !== want) errors++;
         end
      end
   end

   task automatic send_pair(logic [31:0] fs, fe, ss, se);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_fs <= fs; req_fe <= fe; req_ss <= ss; req_se <= se;
      expected_q.push_back(predict_closeness(fs, fe, ss, se));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [30:0] v);
      drain();
      csr_write <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_EPS) eps_val = v; else tol_val = v[15:0];
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom_range(0, 255) - 128;
      endcase
   endfunction

   task automatic test_directed;
      logic [31:0] mx, mn;
      mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
      send_pair(0, 0, 0, 0);
      send_pair(0, 5, 0, 9);
      send_pair(5, 0, 9, 0);
      send_pair(5, 9, 1, 2);
      send_pair(10, -10, 0, 0);
      send_pair(-3, 7, 0, 0);
      send_pair(mx, mn, mn, mx);
      send_pair(mn, mx, mx, mn);
      send_pair(mx, mx, mn, mn);
      send_pair(mn, mn, mx, mx);
      send_pair(1, -1, 0, 0);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
      send_pair(1, 2, 3, 1);
   endtask

   task automatic test_random(int n, int narrow_pct);
      int mode;
      logic [31:0] a, b, c, d;
      repeat (n) begin
         mode = ($urandom_range(99) < narrow_pct) ? 2 : $urandom_range(0, 1);
         c = rand_coord(mode); d = rand_coord(mode);
         a = c + rand_coord(mode == 0 ? 1 : mode);
         b = d + rand_coord(mode == 0 ? 1 : mode);
         if ($urandom_range(9) == 0) a = rand_coord(0);
         send_pair(a, b, c, d);
      end
   endtask

   task automatic test_exact_mode;
      write_csr(CSR_TOL, 31'd0);
      write_csr(CSR_EPS, 31'd0);
      test_directed();
      test_random(120, 40);
      write_csr(CSR_TOL, 31'h0000_FFFF);
      test_random(100, 30);
   endtask

   task automatic test_tolerance_mode;
      write_csr(CSR_TOL, 31'd1);
      write_csr(CSR_EPS, 31'h0001_0000);
      test_directed();
      send_idle_pct = 68;
      test_random(200, 30);
      write_csr(CSR_EPS, 31'h7FFF_FFFF);
      send_idle_pct = 0; stall_pct = 68;
      test_directed();
      test_random(150, 20);
      write_csr(CSR_EPS, 31'd2);
      write_csr(CSR_TOL, 31'd0);
      send_idle_pct = 22; stall_pct = 22;
      test_random(150, 60);
      write_csr(CSR_EPS, 31'($urandom_range(3, 32'h0008_0000)));
      write_csr(CSR_TOL, 31'($urandom_range(0, 32'h0000_FFFF)));
      send_idle_pct = 0; stall_pct = 0;
      test_random(250, 30);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_exact_mode();
      test_tolerance_mode();
      drain();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
